// ----- hw/rtl/lpx_pkg.sv -----
// Shared types, constants and helpers for the LiDAR packet to XYZ point block.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package lpx_pkg;

	localparam int PointsPerFrame  = 16384;
	localparam int PacketsPerFrame = 64;
	localparam int BlocksPerPacket = 16;
	localparam int BeamsUsed       = 16;
	localparam int QueueDepth      = 4;

	localparam int BlockBytes    = 788;
	localparam int WordBase      = 16;
	localparam int WordBytes     = 12;
	localparam int WordsPerBlock = 64;
	localparam int MaxBeams      = 16;
	localparam int CordicSteps   = 19;

	localparam logic [16:0] TprReset = 17'd90112;
	localparam logic [11:0] TpbReset = 12'd88;
	localparam logic [16:0] DegTurn  = 17'd92160;
	localparam logic signed [33:0] KGain = 34'sd652032874;

	// Q8.8 degrees to turn phase: (u * 2^13 + 22) / 45, the divide done as
	// a multiply by ceil(2^37 / 45) and a 37-bit shift, exact below 2^31
	localparam logic [31:0] DegRecip = 32'd3054198967;
	localparam logic [30:0] DegRound = 31'd22;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_ALT  = 2'd1,
		KIND_AZ   = 2'd2
	} kind_t;

	typedef enum logic {
		REG_TPR = 1'b0,
		REG_TPB = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [19:0]        rng;
		logic [17:0]        enc_sum;
		logic signed [16:0] az;
		logic signed [16:0] alt;
		logic [13:0]        num;
		logic               last;
	} job_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_DENC,
		BK_DAZ,
		BK_DALT,
		BK_CTH,
		BK_CPH,
		BK_MCC,
		BK_MSC,
		BK_XH,
		BK_XL,
		BK_YH,
		BK_YL,
		BK_ZM,
		BK_ZF
	} bk_state_t;

	// atan(2^-i) as a fraction of a turn, 2^24 per turn
	function automatic logic [21:0] atan_phase(input logic [4:0] i);
		logic [21:0] v;
		unique case (i)
			5'd0:  v = 22'd2097152;
			5'd1:  v = 22'd1238021;
			5'd2:  v = 22'd654136;
			5'd3:  v = 22'd332050;
			5'd4:  v = 22'd166669;
			5'd5:  v = 22'd83416;
			5'd6:  v = 22'd41718;
			5'd7:  v = 22'd20860;
			5'd8:  v = 22'd10430;
			5'd9:  v = 22'd5215;
			5'd10: v = 22'd2608;
			5'd11: v = 22'd1304;
			5'd12: v = 22'd652;
			5'd13: v = 22'd326;
			5'd14: v = 22'd163;
			5'd15: v = 22'd81;
			5'd16: v = 22'd41;
			5'd17: v = 22'd20;
			5'd18: v = 22'd10;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lpx_div.sv -----
// Bit-serial long divider: remainder of num / den, then optional 24 fraction bits
// rounded half up. Depends on lpx_pkg.
`default_nettype none

module lpx_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [17:0] num,
	input  wire logic [16:0] den,
	input  wire logic        frac_en,
	output logic             busy,
	output logic             done,
	output logic [16:0]      rem,
	output logic [23:0]      phase
);
	import lpx_pkg::*;

	logic        run_q, done_q;
	logic [5:0]  step_q, last_q;
	logic [17:0] num_q;
	logic [16:0] rem_q, den_q;
	logic [23:0] quo_q;
	logic [17:0] trial, diff;
	logic        ge, rnd;

	assign trial = {rem_q, num_q[17]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign rnd   = ({1'b0, rem_q} + {2'b0, den_q[16:1]}) >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			last_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
				last_q <= frac_en ? 6'd41 : 6'd17;
			end else if (run_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == last_q) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= (den == '0) ? 17'd1 : den;
		end else if (run_q) begin
			num_q <= {num_q[16:0], 1'b0};
			rem_q <= ge ? diff[16:0] : trial[16:0];
			quo_q <= {quo_q[22:0], ge};
		end
	end

	assign busy  = run_q | done_q;
	assign done  = done_q;
	assign rem   = rem_q;
	assign phase = quo_q + {23'd0, rnd};

endmodule

`default_nettype wire

// ----- hw/rtl/lpx_cordic.sv -----
// Iterative rotation CORDIC: sine and cosine of a 24-bit turn phase, Q16 results.
// One iteration per cycle; depends on lpx_pkg.
`default_nettype none

module lpx_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [23:0]        phase,
	output logic                    done,
	output logic signed [17:0]      sin_v,
	output logic signed [17:0]      cos_v
);
	import lpx_pkg::*;

	localparam logic [4:0] LastStep = 5'(CordicSteps - 1);

	logic               run_q, done_q;
	logic [4:0]         i_q;
	logic [1:0]         quad_q;
	logic signed [33:0] x_q, y_q, dx, dy;
	logic signed [24:0] z_q, at;
	logic signed [17:0] xr, yr;

	function automatic logic signed [17:0] round_q16(input logic signed [33:0] v);
		logic signed [33:0] t;
		logic signed [17:0] r;
		t = (v + 34'sd8192) >>> 14;
		if (t > 34'sd65536)
			r = 18'sd65536;
		else if (t < -34'sd65536)
			r = -18'sd65536;
		else
			r = t[17:0];
		return r;
	endfunction

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = {3'b000, atan_phase(i_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == LastStep) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= KGain;
			y_q    <= '0;
			z_q    <= {3'b000, phase[21:0]};
			quad_q <= phase[23:22];
		end else if (run_q) begin
			if (!z_q[24]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign xr = round_q16(x_q);
	assign yr = round_q16(y_q);

	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_v = xr;
				sin_v = yr;
			end
			2'd1: begin
				cos_v = -yr;
				sin_v = xr;
			end
			2'd2: begin
				cos_v = -xr;
				sin_v = -yr;
			end
			default: begin
				cos_v = yr;
				sin_v = -xr;
			end
		endcase
	end

	assign done = done_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lpx_queue.sv -----
// Short job queue between the packet parser and the point engine.
// Depends on lpx_pkg for the job type.
`default_nettype none

module lpx_queue #(
	parameter int DEPTH = lpx_pkg::QueueDepth
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lpx_pkg::job_t push_data,
	output logic               full,
	input  wire logic          pop,
	output lpx_pkg::job_t      pop_data,
	output logic               empty
);
	import lpx_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] Depth   = CntW'(DEPTH);

	job_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;

	assign full     = cnt_q == Depth;
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lpx_front.sv -----
// Packet parser: byte position, encoder count, range assembly, angle tables,
// block tick accumulation. Pushes one job per point. Depends on lpx_pkg, lpx_div.
`default_nettype none

module lpx_front #(
	parameter int POINTS_PER_FRAME  = lpx_pkg::PointsPerFrame,
	parameter int PACKETS_PER_FRAME = lpx_pkg::PacketsPerFrame,
	parameter int BLOCKS_PER_PACKET = lpx_pkg::BlocksPerPacket,
	parameter int BEAMS_USED        = lpx_pkg::BeamsUsed
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         kind,
	input  wire logic [7:0]         byte_value,
	input  wire logic [3:0]         beam_index,
	input  wire logic signed [16:0] angle_q8,
	input  wire logic [16:0]        tpr,
	input  wire logic [11:0]        tpb,
	input  wire logic               q_full,
	output logic                    q_push,
	output lpx_pkg::job_t           q_data
);
	import lpx_pkg::*;

	localparam int TotalBlocks = PACKETS_PER_FRAME * BLOCKS_PER_PACKET;
	localparam int BlkW        = $clog2(TotalBlocks + 1);
	localparam int PtsW        = $clog2(POINTS_PER_FRAME + 1);
	localparam int Beams       = (BEAMS_USED < MaxBeams) ? BEAMS_USED : MaxBeams;
	localparam logic [BlkW-1:0] LastBlk = BlkW'(TotalBlocks - 1);
	localparam logic [PtsW-1:0] PtsMax  = PtsW'(POINTS_PER_FRAME);
	localparam logic [PtsW-1:0] LastPt  = PtsW'(POINTS_PER_FRAME - 1);
	localparam logic [4:0]      BeamLim = 5'(Beams);
	localparam logic [4:0]      BeamTop = 5'(Beams - 1);
	localparam logic [9:0]      BlkEnd  = 10'(BlockBytes - 1);
	localparam logic [9:0]      WBase   = 10'(WordBase);
	localparam logic [3:0]      SubEnd  = 4'(WordBytes - 1);
	localparam logic [6:0]      ChLim   = 7'(WordsPerBlock);

	logic               done_q;
	logic [BlkW-1:0]    blk_q;
	logic [9:0]         b_q;
	logic [3:0]         sub_q;
	logic [6:0]         ch_q;
	logic [15:0]        enc_q;
	logic [15:0]        rng_q;
	logic [PtsW-1:0]    pts_q;
	logic [16:0]        bt_q;
	logic signed [16:0] alt_q [MaxBeams];
	logic signed [16:0] az_q  [MaxBeams];

	logic        acc, is_byte, hit, emit, blk_end;
	logic [3:0]  beam;
	logic        md_busy, md_done;
	logic [16:0] md_rem;
	logic [23:0] md_phase;

	assign in_ready = !md_busy && !q_full;
	assign acc      = in_valid && in_ready;
	assign is_byte  = acc && (kind == KIND_BYTE) && !done_q;
	assign beam     = ch_q[5:2];
	assign hit      = (b_q >= WBase) && (ch_q < ChLim) && (ch_q[1:0] == 2'd2)
	                  && ({1'b0, beam} < BeamLim);
	assign emit     = is_byte && hit && (sub_q == 4'd2) && (pts_q < PtsMax);
	assign blk_end  = is_byte && (b_q == BlkEnd);

	lpx_div u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (blk_end),
		.num     ({1'b0, bt_q} + {6'd0, tpb}),
		.den     (tpr),
		.frac_en (1'b0),
		.busy    (md_busy),
		.done    (md_done),
		.rem     (md_rem),
		.phase   (md_phase)
	);

	assign q_push       = emit;
	assign q_data.rng     = {byte_value[3:0], rng_q};
	assign q_data.enc_sum = {2'b00, enc_q} + {1'b0, bt_q};
	assign q_data.az      = az_q[beam];
	assign q_data.alt     = alt_q[beam];
	assign q_data.num     = 14'(pts_q);
	assign q_data.last    = ((blk_q == LastBlk) && ({1'b0, beam} == BeamTop))
	                        || (pts_q == LastPt) || (md_phase == 24'hFFFFFF && 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			blk_q  <= '0;
			b_q    <= '0;
			sub_q  <= '0;
			ch_q   <= '0;
			enc_q  <= '0;
			rng_q  <= '0;
			pts_q  <= '0;
			bt_q   <= '0;
			for (int i = 0; i < MaxBeams; i++) begin
				alt_q[i] <= '0;
				az_q[i]  <= '0;
			end
		end else begin
			if (md_done)
				bt_q <= md_rem;
			if (acc && kind == KIND_ALT)
				alt_q[beam_index] <= angle_q8;
			if (acc && kind == KIND_AZ)
				az_q[beam_index] <= angle_q8;
			if (is_byte) begin
				if (blk_q == '0 && b_q == 10'd12)
					enc_q <= {8'd0, byte_value};
				else if (blk_q == '0 && b_q == 10'd13)
					enc_q[15:8] <= byte_value;
				if (hit && sub_q == 4'd0)
					rng_q[7:0] <= byte_value;
				if (hit && sub_q == 4'd1)
					rng_q[15:8] <= byte_value;
				if (emit)
					pts_q <= pts_q + 1'b1;
				if (b_q == BlkEnd) begin
					b_q   <= '0;
					sub_q <= '0;
					ch_q  <= '0;
					if (blk_q == LastBlk)
						done_q <= 1'b1;
					else
						blk_q <= blk_q + 1'b1;
				end else begin
					b_q <= b_q + 10'd1;
					if (b_q >= WBase) begin
						if (sub_q == SubEnd) begin
							sub_q <= '0;
							ch_q  <= ch_q + 7'd1;
						end else begin
							sub_q <= sub_q + 4'd1;
						end
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lpx_back.sv -----
// Point engine: encoder phase by serial division, table angle phases by reciprocal
// product, sin/cos by CORDIC, products by a shared multiplier, result held in an
// output register. Depends on lpx_pkg, lpx_div, lpx_cordic.
`default_nettype none

module lpx_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	output logic               q_pop,
	input  wire lpx_pkg::job_t q_data,
	input  wire logic [16:0]   tpr,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [20:0]        x_coord,
	output logic [20:0]        y_coord,
	output logic [20:0]        z_coord,
	output logic [13:0]        point_number,
	output logic               frame_last
);
	import lpx_pkg::*;

	bk_state_t st_q, st_d;
	job_t      job_q;

	logic [23:0]        pha_q, phb_q;
	logic signed [17:0] sth_q, cth_q, sph_q, cph_q;
	logic signed [39:0] prod_q;
	logic signed [35:0] cc_q, sc_q;
	logic signed [57:0] acc_q, sum;
	logic [20:0]        x_q, y_q;
	logic               ovalid_q;
	logic [20:0]        ox_q, oy_q, oz_q;
	logic [13:0]        onum_q;
	logic               olast_q;

	logic               div_start, div_done, div_busy;
	logic [17:0]        div_num;
	logic [16:0]        div_den, div_rem;
	logic [23:0]        div_phase;
	logic               cor_start, cor_done;
	logic [23:0]        cor_phase;
	logic signed [17:0] cor_sin, cor_cos;
	logic               mul_en, out_load;
	logic signed [20:0] ma;
	logic signed [18:0] mb;
	logic signed [39:0] mp;
	logic signed [20:0] rs;
	logic signed [16:0] ang_sel;
	logic [17:0]        ang_u;
	logic [30:0]        ang_n;
	logic [62:0]        ang_p;
	logic [23:0]        ang_ph;

	function automatic logic [20:0] fin32(input logic signed [57:0] v);
		logic signed [57:0] t;
		logic [20:0] r;
		t = (v + 58'sd2147483648) >>> 32;
		if (t > 58'sd1048575)
			r = 21'd1048575;
		else if (t < -58'sd1048575)
			r = 21'(-21'sd1048575);
		else
			r = t[20:0];
		return r;
	endfunction

	function automatic logic [20:0] fin16(input logic signed [39:0] v);
		logic signed [39:0] t;
		logic [20:0] r;
		t = (v + 40'sd32768) >>> 16;
		if (t > 40'sd1048575)
			r = 21'd1048575;
		else if (t < -40'sd1048575)
			r = 21'(-21'sd1048575);
		else
			r = t[20:0];
		return r;
	endfunction

	lpx_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (div_num),
		.den     (div_den),
		.frac_en (1'b1),
		.busy    (div_busy),
		.done    (div_done),
		.rem     (div_rem),
		.phase   (div_phase)
	);

	lpx_cordic u_cor (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.phase  (cor_phase),
		.done   (cor_done),
		.sin_v  (cor_sin),
		.cos_v  (cor_cos)
	);

	assign rs  = {1'b0, job_q.rng};
	assign sum = acc_q + {{18{prod_q[39]}}, prod_q};
	assign mp  = ma * mb;

	// table angle to turn phase, one shared reciprocal multiplier
	assign ang_sel = (st_q == BK_DALT) ? job_q.alt : job_q.az;
	assign ang_u   = {ang_sel[16], ang_sel} + {1'b0, DegTurn};
	assign ang_n   = {ang_u, 13'd0} + DegRound;
	assign ang_p   = 63'(ang_n) * 63'(DegRecip);
	assign ang_ph  = ang_p[60:37];

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (!q_empty) st_d = BK_DENC;
			BK_DENC: if (div_done) st_d = BK_DAZ;
			BK_DAZ:  st_d = BK_DALT;
			BK_DALT: st_d = BK_CTH;
			BK_CTH:  if (cor_done) st_d = BK_CPH;
			BK_CPH:  if (cor_done) st_d = BK_MCC;
			BK_MCC:  st_d = BK_MSC;
			BK_MSC:  st_d = BK_XH;
			BK_XH:   st_d = BK_XL;
			BK_XL:   st_d = BK_YH;
			BK_YH:   st_d = BK_YL;
			BK_YL:   st_d = BK_ZM;
			BK_ZM:   st_d = BK_ZF;
			BK_ZF:   if (!ovalid_q || out_ready) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		div_num   = q_data.enc_sum;
		div_den   = tpr;
		cor_start = 1'b0;
		cor_phase = pha_q;
		mul_en    = 1'b0;
		ma        = rs;
		mb        = '0;
		out_load  = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				q_pop     = !q_empty;
				div_start = !q_empty;
			end
			BK_DENC: ;
			BK_DAZ:  ;
			BK_DALT: cor_start = 1'b1;
			BK_CTH: begin
				cor_start = cor_done;
				cor_phase = phb_q;
			end
			BK_CPH: ;
			BK_MCC: begin
				mul_en = 1'b1;
				ma     = {{3{cth_q[17]}}, cth_q};
				mb     = {cph_q[17], cph_q};
			end
			BK_MSC: begin
				mul_en = 1'b1;
				ma     = {{3{sth_q[17]}}, sth_q};
				mb     = {cph_q[17], cph_q};
			end
			BK_XH: begin
				mul_en = 1'b1;
				mb     = cc_q[35:17];
			end
			BK_XL: begin
				mul_en = 1'b1;
				mb     = {2'b00, cc_q[16:0]};
			end
			BK_YH: begin
				mul_en = 1'b1;
				mb     = sc_q[35:17];
			end
			BK_YL: begin
				mul_en = 1'b1;
				mb     = {2'b00, sc_q[16:0]};
			end
			BK_ZM: begin
				mul_en = 1'b1;
				mb     = {sph_q[17], sph_q};
			end
			BK_ZF: out_load = !ovalid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= BK_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_load)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= q_data;
		if (st_q == BK_DENC && div_done)
			pha_q <= div_phase;
		if (st_q == BK_DAZ)
			pha_q <= pha_q + ang_ph;
		if (st_q == BK_DALT)
			phb_q <= ang_ph;
		if (st_q == BK_CTH && cor_done) begin
			sth_q <= cor_sin;
			cth_q <= cor_cos;
		end
		if (st_q == BK_CPH && cor_done) begin
			sph_q <= cor_sin;
			cph_q <= cor_cos;
		end
		if (mul_en)
			prod_q <= mp;
		if (st_q == BK_MSC)
			cc_q <= prod_q[35:0];
		if (st_q == BK_XH)
			sc_q <= prod_q[35:0];
		if (st_q == BK_XL || st_q == BK_YL)
			acc_q <= {prod_q[39], prod_q, 17'd0};
		if (st_q == BK_YH)
			x_q <= fin32(sum);
		if (st_q == BK_ZM)
			y_q <= fin32(-sum);
		if (out_load) begin
			ox_q    <= x_q;
			oy_q    <= y_q;
			oz_q    <= fin16(prod_q);
			onum_q  <= job_q.num;
			olast_q <= job_q.last;
		end
	end

	assign out_valid    = ovalid_q;
	assign x_coord      = ox_q;
	assign y_coord      = oy_q;
	assign z_coord      = oz_q;
	assign point_number = onum_q;
	assign frame_last   = olast_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lidar_packet_to_xyz_points.sv -----
// Top level of the LiDAR packet to XYZ point converter: configuration registers,
// packet parser, job queue and point engine. Depends on lpx_pkg and all lpx_ modules.
//
// Usage:
//  s_* channel: one item per handshake. s_tuser is the kind (packet byte, altitude
//   table load, azimuth table load); table loads give no point.
//  m_* channel: one point per third range byte of beams 0..15 in each block;
//   m_tlast marks the last point of the frame.
//  cfg_*: ticks per revolution (index 0) and ticks per block (index 1), always ready;
//   write only while no item is in flight and 20 cycles after the last one.
//  Throughput: the parser takes one item per cycle while the job queue has room, but stalls
//   after the last byte of each 788-byte block while the serial divider folds the block ticks.
//   For each point the engine runs a 42-step division for the encoder phase, two
//   reciprocal products, two 19-step CORDIC runs and the multiplier steps, one point
//   at a time. A 4-entry job queue sits between the two.
//  Reset clears positions, counters and angle tables; registers return to
//   90112 and 88 ticks. After the frame, packet bytes are dropped until reset.
//  When m_tready is low the result stays in the output register; the engine
//   finishes the next point and waits, then the queue fills and s_tready drops.
`default_nettype none

module lidar_packet_to_xyz_points #(
	parameter int POINTS_PER_FRAME  = lpx_pkg::PointsPerFrame,
	parameter int PACKETS_PER_FRAME = lpx_pkg::PacketsPerFrame,
	parameter int BLOCKS_PER_PACKET = lpx_pkg::BlocksPerPacket,
	parameter int BEAMS_USED        = lpx_pkg::BeamsUsed,
	parameter int QUEUE_DEPTH       = lpx_pkg::QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // byte_value[7:0], beam_index[11:8], angle_q8[28:12]
	input  wire logic [1:0]  s_tuser,   // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // x[20:0], y[41:21], z[62:42], point_number[76:63]
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [16:0] cfg_data
);
	import lpx_pkg::*;

	logic [16:0] tpr_q;
	logic [11:0] tpb_q;
	logic        q_push, q_full, q_pop, q_empty;
	job_t        q_wdata, q_rdata;
	logic [20:0] x_c, y_c, z_c;
	logic [13:0] pnum;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpr_q <= TprReset;
			tpb_q <= TpbReset;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TPR: tpr_q <= cfg_data;
				REG_TPB: tpb_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	lpx_front #(
		.POINTS_PER_FRAME  (POINTS_PER_FRAME),
		.PACKETS_PER_FRAME (PACKETS_PER_FRAME),
		.BLOCKS_PER_PACKET (BLOCKS_PER_PACKET),
		.BEAMS_USED        (BEAMS_USED)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.kind       (s_tuser),
		.byte_value (s_tdata[7:0]),
		.beam_index (s_tdata[11:8]),
		.angle_q8   (s_tdata[28:12]),
		.tpr        (tpr_q),
		.tpb        (tpb_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	lpx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	lpx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_data       (q_rdata),
		.tpr          (tpr_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.x_coord      (x_c),
		.y_coord      (y_c),
		.z_coord      (z_c),
		.point_number (pnum),
		.frame_last   (m_tlast)
	);

	assign m_tdata = {3'b000, pnum, z_c, y_c, x_c};

endmodule

`default_nettype wire
